// ----- src/lexs_pkg.sv -----
// ----------------------------------------------------------------------------
// lexs_pkg
// Types, constants and elaboration-time curve tables for the log / exp
// intensity scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lexs_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 16;
  localparam int POWER_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CURVE_DEPTH = 256;
  localparam int TAB_IDX_W   = 8;
  localparam int POWER_N     = 51;
  localparam int POWER_MAX   = 50;
  localparam int MAG_W       = 6;
  localparam int X_W         = 37;
  localparam int STRETCH_W   = 47;
  localparam int GAIN_W      = 51;
  localparam int V_W         = 48;
  localparam int DNUM_W      = 69;
  localparam int DIV_STEPS   = 69;
  localparam int DCNT_W      = 7;

  localparam longint unsigned ONE30       = 64'd1 << 30;
  localparam longint unsigned LN2_Q30     = 64'd744261118;
  localparam longint unsigned LOG2_10_Q32 = 64'd14267572527;
  localparam logic [33:0]     GAIN_NEG_K  = 34'd12929139860;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN_LOW  = 2'd0,
    REG_DOMAIN_HIGH = 2'd1,
    REG_INDEX_MAX   = 2'd2,
    REG_POWER       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DRV_IDLE,
    DRV_PREP,
    DRV_DIV
  } drv_state_t;

  typedef struct packed {
    logic               valid;
    logic               bypass;
    logic [INDEX_W-1:0] pre_idx;
  } lane_ctl_t;

  typedef logic [31:0]          exp_arr_t [CURVE_DEPTH];
  typedef logic [32:0]          log_arr_t [CURVE_DEPTH];
  typedef logic [X_W-1:0]       x_arr_t   [POWER_N];
  typedef logic [STRETCH_W-1:0] k30_arr_t [POWER_N];

  // 2^x on [0,1] in Q30, series sum
  function automatic logic [31:0] exp_entry(input int unsigned i);
    longint unsigned u;
    longint unsigned term;
    longint unsigned sum;
    if (i >= CURVE_DEPTH) return 32'h8000_0000;
    u = (longint'(i) * LN2_Q30) / CURVE_DEPTH;
    term = ONE30;
    sum = ONE30;
    // term k is term k-1 times u over k, floored at each step
    term = ((term * u) >> 30) / 1;  sum = sum + term;
    term = ((term * u) >> 30) / 2;  sum = sum + term;
    term = ((term * u) >> 30) / 3;  sum = sum + term;
    term = ((term * u) >> 30) / 4;  sum = sum + term;
    term = ((term * u) >> 30) / 5;  sum = sum + term;
    term = ((term * u) >> 30) / 6;  sum = sum + term;
    term = ((term * u) >> 30) / 7;  sum = sum + term;
    term = ((term * u) >> 30) / 8;  sum = sum + term;
    term = ((term * u) >> 30) / 9;  sum = sum + term;
    term = ((term * u) >> 30) / 10; sum = sum + term;
    term = ((term * u) >> 30) / 11; sum = sum + term;
    term = ((term * u) >> 30) / 12; sum = sum + term;
    term = ((term * u) >> 30) / 13; sum = sum + term;
    term = ((term * u) >> 30) / 14; sum = sum + term;
    term = ((term * u) >> 30) / 15; sum = sum + term;
    term = ((term * u) >> 30) / 16; sum = sum + term;
    term = ((term * u) >> 30) / 17; sum = sum + term;
    term = ((term * u) >> 30) / 18; sum = sum + term;
    term = ((term * u) >> 30) / 19; sum = sum + term;
    term = ((term * u) >> 30) / 20; sum = sum + term;
    term = ((term * u) >> 30) / 21; sum = sum + term;
    term = ((term * u) >> 30) / 22; sum = sum + term;
    term = ((term * u) >> 30) / 23; sum = sum + term;
    term = ((term * u) >> 30) / 24; sum = sum + term;
    return 32'(sum);
  endfunction

  // log2 on [1,2] in Q32, one bit per squaring
  function automatic logic [32:0] log_entry(input int unsigned i);
    longint unsigned m;
    longint unsigned r;
    if (i >= CURVE_DEPTH) return 33'h1_0000_0000;
    m = ONE30 + (longint'(i) << 30) / CURVE_DEPTH;
    r = 0;
    for (int k = 0; k < 32; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (ONE30 << 1)) begin
        m = m >> 1;
        r = r | 64'd1;
      end
    end
    return 33'(r);
  endfunction

  function automatic exp_arr_t exp_table(input int unsigned ofs);
    exp_arr_t t;
    for (int i = 0; i < CURVE_DEPTH; i++) t[i] = exp_entry(i + ofs);
    return t;
  endfunction

  function automatic log_arr_t log_table(input int unsigned ofs);
    log_arr_t t;
    for (int i = 0; i < CURVE_DEPTH; i++) t[i] = log_entry(i + ofs);
    return t;
  endfunction

  function automatic longint unsigned pow2_q30(input longint unsigned x);
    longint unsigned n;
    longint unsigned frac;
    longint unsigned e0;
    longint unsigned e1;
    longint unsigned m;
    n = x >> 32;
    frac = x & 64'hFFFF_FFFF;
    e0 = exp_entry(int'(frac >> 24));
    e1 = exp_entry(int'(frac >> 24) + 1);
    m = e0 + (((e1 - e0) * (frac & 64'hFF_FFFF)) >> 24);
    if (n > 31) n = 31;
    return m << n;
  endfunction

  function automatic x_arr_t x_table();
    x_arr_t t;
    for (int a = 0; a < POWER_N; a++) t[a] = X_W'((longint'(a) * LOG2_10_Q32) / 10);
    return t;
  endfunction

  function automatic k30_arr_t k30_table();
    k30_arr_t t;
    for (int a = 0; a < POWER_N; a++)
      t[a] = STRETCH_W'(pow2_q30((longint'(a) * LOG2_10_Q32) / 10) - ONE30);
    return t;
  endfunction

  localparam exp_arr_t EXP_BASE = exp_table(0);
  localparam exp_arr_t EXP_NEXT = exp_table(1);
  localparam log_arr_t LOG_BASE = log_table(0);
  localparam log_arr_t LOG_NEXT = log_table(1);
  localparam x_arr_t   X_TAB    = x_table();
  localparam k30_arr_t K30_TAB  = k30_table();

endpackage

`default_nettype wire

// ----- src/log_exp_intensity_scaler_core.sv -----
// ----------------------------------------------------------------------------
// log_exp_intensity_scaler_core
// Maps signed samples to colour indices through a linear, log or exp curve.
// ----------------------------------------------------------------------------
// One sample is taken per clock while busy is low; its index appears on
// out_colour_index with a one-cycle out_valid strobe, in order, and cannot
// be held off. The fraction comes from a 16-stage restoring divider, the
// curve from table interpolation and a split gain multiplier.
// A register write makes busy high while the curve state is recomputed; for a
// log or exp curve the gain comes from a bit-serial divider.
`default_nettype none

module log_exp_intensity_scaler_core
  import lexs_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire  [SAMPLE_W-1:0]   in_sample_value,
  output logic                  out_valid,
  output logic [INDEX_W-1:0]    out_colour_index,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAT   = 31;
  localparam int ST_M1 = 19;

  // configuration
  logic [SAMPLE_W-1:0] domain_low_r, domain_high_r;
  logic [INDEX_W-1:0]  index_max_r;
  logic [POWER_W-1:0]  power_r;
  logic                cfg_wr;

  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      domain_low_r  <= '0;
      domain_high_r <= SAMPLE_W'(255);
      index_max_r   <= INDEX_W'(255);
      power_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DOMAIN_LOW:  domain_low_r  <= cfg_data[SAMPLE_W-1:0];
        REG_DOMAIN_HIGH: domain_high_r <= cfg_data[SAMPLE_W-1:0];
        REG_INDEX_MAX:   index_max_r   <= cfg_data[INDEX_W-1:0];
        REG_POWER:       power_r       <= cfg_data[POWER_W-1:0];
        default:         ;
      endcase
    end
  end

  logic [SAMPLE_W-1:0] lo_b, hi_b;
  logic                p_neg;
  logic [POWER_W-1:0]  p_abs;
  logic [MAG_W-1:0]    a_cur;
  logic                p_zero;

  always_comb begin
    lo_b   = {~domain_low_r[SAMPLE_W-1], domain_low_r[SAMPLE_W-2:0]};
    hi_b   = {~domain_high_r[SAMPLE_W-1], domain_high_r[SAMPLE_W-2:0]};
    p_neg  = power_r[POWER_W-1];
    p_abs  = p_neg ? POWER_W'(8'd128 - {1'b0, power_r}) : power_r;
    a_cur  = (p_abs > POWER_W'(POWER_MAX)) ? MAG_W'(POWER_MAX) : p_abs[MAG_W-1:0];
    p_zero = (a_cur == '0);
  end

  // derived curve state
  drv_state_t            state_r, state_nxt;
  logic [SAMPLE_W-1:0]   span_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [STRETCH_W-1:0]  stretch_r;
  logic [DNUM_W-1:0]     dnum_r;
  logic [STRETCH_W-1:0]  dden_r, drem_r;
  logic [GAIN_W-1:0]     dq_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [STRETCH_W:0]    rem_sh, rem_new;
  logic                  dge;
  logic [INDEX_W:0]      r1;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DRV_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      DRV_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        if (cfg_valid) state_nxt = DRV_PREP;
      end
      DRV_PREP: state_nxt = p_zero ? DRV_IDLE : DRV_DIV;
      DRV_DIV:  if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = DRV_IDLE;
      default:  state_nxt = DRV_IDLE;
    endcase
  end

  always_comb begin
    r1      = {1'b0, index_max_r} + (INDEX_W+1)'(1);
    rem_sh  = {drem_r, dnum_r[DNUM_W-1]};
    dge     = rem_sh >= {1'b0, dden_r};
    rem_new = dge ? rem_sh - {1'b0, dden_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r    <= SAMPLE_W'(255);
      gain_r    <= '0;
      stretch_r <= '0;
    end else if (state_r == DRV_PREP) begin
      span_r <= (hi_b > lo_b) ? hi_b - lo_b : '0;
      drem_r <= '0;
      dq_r   <= '0;
      dcnt_r <= '0;
      if (p_zero) begin
        gain_r    <= '0;
        stretch_r <= '0;
      end else if (p_neg) begin
        stretch_r <= K30_TAB[a_cur];
        dnum_r    <= DNUM_W'(r1) * DNUM_W'(GAIN_NEG_K);
        dden_r    <= STRETCH_W'(a_cur);
      end else begin
        stretch_r <= STRETCH_W'(X_TAB[a_cur]);
        dnum_r    <= {r1, 52'b0};
        dden_r    <= K30_TAB[a_cur];
      end
    end else if (state_r == DRV_DIV) begin
      drem_r <= rem_new[STRETCH_W-1:0];
      dnum_r <= {dnum_r[DNUM_W-2:0], 1'b0};
      dq_r   <= {dq_r[GAIN_W-2:0], dge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
      if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) gain_r <= {dq_r[GAIN_W-2:0], dge};
    end
  end

  // sample pipeline control
  lane_ctl_t ctl_r   [LAT];
  lane_ctl_t ctl_mod [LAT];

  logic [SAMPLE_W-1:0] s0_r;
  logic                le_lo, ge_hi;
  logic [INDEX_W-1:0]  idx0;

  always_comb begin
    for (int k = 0; k < LAT; k++) ctl_mod[k] = ctl_r[k];
    le_lo = s0_r <= lo_b;
    ge_hi = s0_r >= hi_b;
    if (span_r == '0) begin
      ctl_mod[0].bypass  = 1'b1;
      ctl_mod[0].pre_idx = le_lo ? '0 : index_max_r;
    end
    if (p_zero && !ctl_r[ST_M1].bypass) begin
      ctl_mod[ST_M1].bypass  = 1'b1;
      ctl_mod[ST_M1].pre_idx = idx0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= '{valid: start && !busy, bypass: 1'b0, pre_idx: '0};
      for (int k = 1; k < LAT; k++) ctl_r[k] <= ctl_mod[k-1];
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= {~in_sample_value[SAMPLE_W-1], in_sample_value[SAMPLE_W-2:0]};
  end

  // fraction divider, one quotient bit per stage
  logic [SAMPLE_W-1:0] dv_rem_r [FRAC_W+1];
  logic [FRAC_W-1:0]   dv_q_r   [FRAC_W+1];
  logic                dv_full_r[FRAC_W+1];
  logic [SAMPLE_W:0]   dv_two   [FRAC_W];
  logic                dv_ge    [FRAC_W];

  always_comb begin
    for (int j = 0; j < FRAC_W; j++) begin
      dv_two[j] = {dv_rem_r[j], 1'b0};
      dv_ge[j]  = dv_two[j] >= {1'b0, span_r};
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0]  <= (le_lo || ge_hi) ? '0 : s0_r - lo_b;
    dv_q_r[0]    <= '0;
    dv_full_r[0] <= ge_hi && !le_lo;
    for (int j = 0; j < FRAC_W; j++) begin
      dv_rem_r[j+1]  <= dv_ge[j] ? SAMPLE_W'(dv_two[j] - {1'b0, span_r})
                                 : dv_two[j][SAMPLE_W-1:0];
      dv_q_r[j+1]    <= {dv_q_r[j][FRAC_W-2:0], dv_ge[j]};
      dv_full_r[j+1] <= dv_full_r[j];
    end
  end

  // curve datapath
  logic [FRAC_W:0]            f_r;
  logic [FRAC_W+23:0]         pl_r;
  logic [FRAC_W+22:0]         ph_r;
  logic [INDEX_W+FRAC_W:0]    rmf_r;
  logic [63:0]                t_sum;
  logic [V_W-1:0]             v2_r, v1_r, m_sh;
  logic [INDEX_W+FRAC_W+1:0]  rnd;
  logic [4:0]                 n_l1, n1_r, n2_r, n3_r, n4_r, n5_r;
  logic [TAB_IDX_W-1:0]       ti_r;
  logic [23:0]                tr_r, tr3_r;
  logic [32:0]                base3_r, base4_r;
  logic [24:0]                diff3_r;
  logic [48:0]                prod4_r;
  logic [X_W-1:0]             w5_r;
  logic [V_W-1:0]             v6_r;
  logic [40:0]                pp_r [3][2];
  logic [64:0]                g2_r [3];
  logic [98:0]                tot_r;
  logic [46:0]                sh;
  logic [INDEX_W-1:0]         oidx_r;

  always_comb begin
    t_sum = 64'(pl_r) + (64'(ph_r) << 24);
    rnd   = (INDEX_W+FRAC_W+2)'(rmf_r) + (INDEX_W+FRAC_W+2)'(1 << (FRAC_W - 1));
    idx0  = rnd[INDEX_W+FRAC_W-1:FRAC_W];
    n_l1  = '0;
    if (p_neg) begin
      for (int j = 1; j <= 17; j++) if (v2_r[30+j]) n_l1 = 5'(j);
    end else begin
      n_l1 = v2_r[36:32];
    end
    m_sh = v1_r >> n1_r;
    sh   = p_neg ? 47'(tot_r[98:64]) : tot_r[98:52];
  end

  always_ff @(posedge clk) begin
    f_r   <= dv_full_r[FRAC_W] ? (FRAC_W+1)'(1 << FRAC_W) : {1'b0, dv_q_r[FRAC_W]};
    // f times stretch, split in two partial products
    pl_r  <= f_r * stretch_r[23:0];
    ph_r  <= f_r * stretch_r[STRETCH_W-1:24];
    rmf_r <= index_max_r * f_r;
    v2_r  <= p_neg ? t_sum[63:16] + V_W'(ONE30) : t_sum[63:16];
    v1_r  <= v2_r;
    n1_r  <= n_l1;
    // table index and interpolation weight
    if (p_neg) begin
      ti_r <= m_sh[29:22];
      tr_r <= {2'b0, m_sh[21:0]};
    end else begin
      ti_r <= v1_r[31:24];
      tr_r <= v1_r[23:0];
    end
    n2_r <= n1_r;
    if (p_neg) begin
      base3_r <= LOG_BASE[ti_r];
      diff3_r <= 25'(LOG_NEXT[ti_r] - LOG_BASE[ti_r]);
    end else begin
      base3_r <= {1'b0, EXP_BASE[ti_r]};
      diff3_r <= 25'(EXP_NEXT[ti_r] - EXP_BASE[ti_r]);
    end
    tr3_r   <= tr_r;
    n3_r    <= n2_r;
    prod4_r <= diff3_r * tr3_r;
    base4_r <= base3_r;
    n4_r    <= n3_r;
    if (p_neg) w5_r <= (X_W'(n4_r) << 32) + X_W'(base4_r) + X_W'(prod4_r >> 22);
    else       w5_r <= X_W'(base4_r) + X_W'(prod4_r >> 24);
    n5_r <= n4_r;
    if (p_neg) v6_r <= V_W'(w5_r);
    else       v6_r <= (V_W'(w5_r[31:0]) << n5_r) - V_W'(ONE30);
    // gain times curve value, 17 x 24 partial products
    for (int k = 0; k < 3; k++) begin
      for (int h = 0; h < 2; h++) pp_r[k][h] <= gain_r[17*k +: 17] * v6_r[24*h +: 24];
      g2_r[k] <= 65'(pp_r[k][0]) + (65'(pp_r[k][1]) << 24);
    end
    tot_r <= 99'(g2_r[0]) + (99'(g2_r[1]) << 17) + (99'(g2_r[2]) << 34);
    if (ctl_r[LAT-2].bypass)                 oidx_r <= ctl_r[LAT-2].pre_idx;
    else if (sh > 47'(index_max_r))          oidx_r <= index_max_r;
    else                                     oidx_r <= sh[INDEX_W-1:0];
  end

  assign out_valid        = ctl_r[LAT-1].valid;
  assign out_colour_index = oidx_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_colour_index <= index_max_r)
    else $error("colour index above index_max");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && span_r == '0 |-> out_colour_index == '0 || out_colour_index == index_max_r)
    else $error("empty domain gave an inner index");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy)
    else $error("no recompute after register write");

endmodule

`default_nettype wire
